[hdl/dqr_pkg.sv]
// ---------------------------------------------------------------------------
// dqr_pkg
// shared types and constants of the captive-portal dns responder
// ---------------------------------------------------------------------------
package dqr_pkg;

   localparam int POS_W = 10;
   localparam int LBL_W = POS_W + 1;
   localparam logic [POS_W-1:0] POS_CAP = '1;
   localparam logic [POS_W-1:0] HDR_LEN = 10'd12;
   localparam logic [POS_W-1:0] LABEL_START = 10'd12;

   // header byte offsets
   localparam logic [3:0] OFS_FLAGS_HI = 4'd2;
   localparam logic [3:0] OFS_FLAGS_LO = 4'd3;
   localparam logic [3:0] OFS_QDCOUNT_HI = 4'd4;
   localparam logic [3:0] OFS_QDCOUNT_LO = 4'd5;
   localparam logic [3:0] OFS_ANCOUNT_HI = 4'd6;
   localparam logic [3:0] OFS_ANCOUNT_LO = 4'd7;
   localparam logic [3:0] OFS_NSCOUNT_HI = 4'd8;
   localparam logic [3:0] OFS_NSCOUNT_LO = 4'd9;
   localparam logic [3:0] OFS_ARCOUNT_HI = 4'd10;
   localparam logic [3:0] OFS_ARCOUNT_LO = 4'd11;

   localparam logic [7:0] FLAGS_HI_OUT = 8'h81;
   localparam logic [7:0] FLAGS_LO_OUT = 8'h80;
   localparam logic [7:0] QR_MASK = 8'h80;

   // type and class after the name end
   localparam logic [LBL_W-1:0] TYPE_CLASS_END = 11'd5;

   // answer record
   localparam int TAIL_LEN = 16;
   localparam int HEAD_LEN = 12;
   localparam int IDX_W = $clog2(TAIL_LEN + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TAIL_LEN);
   localparam logic [7:0] ANSWER_HEAD [HEAD_LEN] = '{
      8'hC0, 8'h0C, 8'h00, 8'h01, 8'h00, 8'h01,
      8'h00, 8'h00, 8'h00, 8'h0A, 8'h00, 8'h04
   };

   typedef struct packed {
      logic       keep;
      logic       eof;
      logic       ok;
      logic [7:0] data;
   } entry_type;

endpackage

[hdl/dns_query_fixed_answer_responder.sv]
// ---------------------------------------------------------------------------
// dns_query_fixed_answer_responder
// answers every dns query with one fixed ipv4 a record
// ---------------------------------------------------------------------------
// usage:
//   req_ carries the query one byte per transaction, req_end_of_frame on the
//   final byte. rsp_ streams the reply: rewritten header, question, and on
//   frame end a 16-byte answer record whose final byte has rsp_reply_last
//   set and rsp_frame_ok giving the verdict (0 means drop the whole reply).
//   csr_ writes the answered address; write it only between frames.
// latency and throughput:
//   a byte shows on rsp_ in the cycle after its transaction. one byte per
//   cycle is taken while rsp_ready stays high. the final byte of a frame
//   holds the result register while the answer record drains (its own
//   byte first, if it is kept); req_ready stays low until the last record
//   byte is taken.
// reset:
//   synchronous, clears the result register's valid flag and index, the
//   frame state and the address register.
// stall:
//   with rsp_ready low a pending result holds and req_ready stays low until
//   it is taken; no byte is lost or repeated.
// ---------------------------------------------------------------------------
module dns_query_fixed_answer_responder #(
   parameter int MAX_MESSAGE = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_frame,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_reply_byte,
   output logic        rsp_reply_last,
   output logic        rsp_frame_ok,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_answer_address
);
   import dqr_pkg::*;

   logic [31:0] answer_address_ff;
   logic        in_accept;
   logic        load;
   logic        take;
   entry_type   entry;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         answer_address_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         answer_address_ff <= csr_answer_address;
      end
   end

   assign req_ready = take;
   assign in_accept = req_valid && req_ready;

   dqr_parse #(
      .MAX_MESSAGE(MAX_MESSAGE)
   ) u_parse (
      .clock(clock),
      .reset(reset),
      .in_accept(in_accept),
      .data_byte(req_data_byte),
      .end_of_frame(req_end_of_frame),
      .load(load),
      .entry(entry)
   );

   dqr_emit u_emit (
      .clock(clock),
      .reset(reset),
      .load(load),
      .entry(entry),
      .answer_address(answer_address_ff),
      .take(take),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_reply_byte(rsp_reply_byte),
      .rsp_reply_last(rsp_reply_last),
      .rsp_frame_ok(rsp_frame_ok)
   );

endmodule

[hdl/dqr_parse.sv]
// ---------------------------------------------------------------------------
// dqr_parse
// per-byte header rewrite, question name walk and frame verdict
// ---------------------------------------------------------------------------
module dqr_parse #(
   parameter int MAX_MESSAGE = 512
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_accept,
   input  logic [7:0]        data_byte,
   input  logic              end_of_frame,
   output logic              load,
   output dqr_pkg::entry_type entry
);
   import dqr_pkg::*;

   localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_MESSAGE);
   localparam logic [LBL_W-1:0] MAX_SUM = LBL_W'(MAX_MESSAGE);
   localparam logic [LBL_W-1:0] TAIL_SUM = LBL_W'(TAIL_LEN);

   logic [POS_W-1:0] byte_position_ff, byte_position_in;
   logic [POS_W-1:0] next_label_start_ff, next_label_start_in;
   logic             name_finished_ff, name_finished_in;
   logic             pointer_second_byte_ff, pointer_second_byte_in;
   logic [POS_W-1:0] q_stop_pos_ff, q_stop_pos_in;
   logic             query_rejected_ff, query_rejected_in;

   logic [POS_W-1:0] pos;
   logic [7:0]       ob;
   logic             keep;
   logic             end_name;
   logic [LBL_W-1:0] qe_sum;
   logic [LBL_W-1:0] label_sum;
   logic             ok;

   always_comb begin
      pos = byte_position_ff;
      ob = data_byte;
      keep = 1'b0;
      end_name = 1'b0;
      byte_position_in = byte_position_ff;
      next_label_start_in = next_label_start_ff;
      name_finished_in = name_finished_ff;
      pointer_second_byte_in = pointer_second_byte_ff;
      q_stop_pos_in = q_stop_pos_ff;
      query_rejected_in = query_rejected_ff;
      qe_sum = {1'b0, pos} + TYPE_CLASS_END;
      label_sum = {1'b0, pos} + {3'b000, data_byte} + LBL_W'(1);
      if (pos < MAX_POS) begin
         keep = 1'b1;
         if (pos < HDR_LEN) begin
            case (pos[3:0])
               OFS_FLAGS_HI: begin
                  if ((data_byte & QR_MASK) != 8'h00) query_rejected_in = 1'b1;
                  ob = FLAGS_HI_OUT;
               end
               OFS_FLAGS_LO: ob = FLAGS_LO_OUT;
               OFS_QDCOUNT_HI: if (data_byte != 8'h00) query_rejected_in = 1'b1;
               OFS_QDCOUNT_LO: if (data_byte != 8'h01) query_rejected_in = 1'b1;
               OFS_ANCOUNT_HI: ob = 8'h00;
               OFS_ANCOUNT_LO: ob = 8'h01;
               OFS_NSCOUNT_HI, OFS_NSCOUNT_LO,
               OFS_ARCOUNT_HI, OFS_ARCOUNT_LO: ob = 8'h00;
               default: ;
            endcase
         end else if (!name_finished_ff) begin
            if (pointer_second_byte_ff) begin
               end_name = 1'b1;
            end else if (pos == next_label_start_ff) begin
               if (data_byte == 8'h00) begin
                  end_name = 1'b1;
               end else if (data_byte[7:6] == 2'b11) begin
                  pointer_second_byte_in = 1'b1;
               end else begin
                  next_label_start_in = (label_sum > {1'b0, POS_CAP}) ?
                                        POS_CAP : label_sum[POS_W-1:0];
               end
            end
         end else if (pos >= q_stop_pos_ff) begin
            keep = 1'b0;
         end
         byte_position_in = pos + POS_W'(1);
      end
      if (end_name) begin
         name_finished_in = 1'b1;
         pointer_second_byte_in = 1'b0;
         if (qe_sum + TAIL_SUM > MAX_SUM) query_rejected_in = 1'b1;
         q_stop_pos_in = (qe_sum > {1'b0, POS_CAP}) ?
                         POS_CAP : qe_sum[POS_W-1:0];
      end
      ok = !query_rejected_in && (byte_position_in >= HDR_LEN) && name_finished_in &&
           (q_stop_pos_in <= byte_position_in);
   end

   always_ff @(posedge clock) begin
      if (reset || (in_accept && end_of_frame)) begin
         byte_position_ff <= '0;
         next_label_start_ff <= LABEL_START;
         name_finished_ff <= 1'b0;
         pointer_second_byte_ff <= 1'b0;
         q_stop_pos_ff <= '0;
         query_rejected_ff <= 1'b0;
      end else if (in_accept) begin
         byte_position_ff <= byte_position_in;
         next_label_start_ff <= next_label_start_in;
         name_finished_ff <= name_finished_in;
         pointer_second_byte_ff <= pointer_second_byte_in;
         q_stop_pos_ff <= q_stop_pos_in;
         query_rejected_ff <= query_rejected_in;
      end
   end

   assign load = in_accept && (keep || end_of_frame);
   assign entry.keep = keep;
   assign entry.eof = end_of_frame;
   assign entry.ok = ok;
   assign entry.data = ob;

endmodule

[hdl/dqr_emit.sv]
// ---------------------------------------------------------------------------
// dqr_emit
// result register: one rewritten byte, then the answer record on frame end
// ---------------------------------------------------------------------------
module dqr_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  dqr_pkg::entry_type entry,
   input  logic [31:0]        answer_address,
   output logic               take,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_reply_byte,
   output logic               rsp_reply_last,
   output logic               rsp_frame_ok
);
   import dqr_pkg::*;

   entry_type        entry_ff, entry_in;
   logic             valid_ff, valid_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             done;
   logic [3:0]       tail_sel;
   logic [7:0]       addr_byte;

   assign done = valid_ff && rsp_ready &&
                 ((idx_ff == LAST_IDX) || ((idx_ff == '0) && !entry_ff.eof));
   assign take = !valid_ff || done;

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      idx_in = idx_ff;
      if (load) begin
         entry_in = entry;
         valid_in = 1'b1;
         idx_in = entry.keep ? '0 : IDX_W'(1);
      end else if (done) begin
         valid_in = 1'b0;
      end else if (valid_ff && rsp_ready) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff <= idx_in;
      end
      entry_ff <= entry_in;
   end

   assign tail_sel = 4'(idx_ff - IDX_W'(1));

   always_comb begin
      case (tail_sel[1:0])
         2'd0: addr_byte = answer_address[31:24];
         2'd1: addr_byte = answer_address[23:16];
         2'd2: addr_byte = answer_address[15:8];
         default: addr_byte = answer_address[7:0];
      endcase
   end

   assign rsp_valid = valid_ff;
   assign rsp_reply_byte = (idx_ff == '0) ? entry_ff.data :
                           (tail_sel < 4'(HEAD_LEN)) ? ANSWER_HEAD[tail_sel] : addr_byte;
   assign rsp_reply_last = (idx_ff == LAST_IDX);
   assign rsp_frame_ok = (idx_ff == LAST_IDX) && entry_ff.ok;

   a_tail_needs_eof: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && idx_ff != '0) |-> entry_ff.eof)
      else $error("answer record emitted without frame end");

   a_tail_advances: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_ready && idx_ff != '0 && idx_ff != LAST_IDX) |=>
      (valid_ff && idx_ff == $past(idx_ff) + IDX_W'(1)))
      else $error("answer record did not advance");

   a_no_load_when_busy: assert property (@(posedge clock) disable iff (reset)
      load |-> take)
      else $error("transaction loaded over a pending result");

endmodule

[tb/dns_query_fixed_answer_responder_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dns_query_fixed_answer_responder_tb
// self-checking bench for the captive-portal dns responder
// ---------------------------------------------------------------------------
// query datagrams are driven one byte per transaction: two short directed
// frames, then random frames, mostly well-formed queries with random labels,
// compression pointers and trailing bytes, the rest broken in various ways.
// a model of the header rewrite, name walk and verdict predicts every reply
// byte, and each reply transaction is compared field by field with the
// oldest prediction.
// the answer address is rewritten between phases while the block is idle.
// ---------------------------------------------------------------------------
module dns_query_fixed_answer_responder_tb;

   localparam int MAX_MESSAGE = 512;
   localparam int HEADER_BYTES = 12;
   localparam int RECORD_BYTES = 16;
   localparam int POS_LIMIT = 1023;
   localparam int QUESTION_TRAILER = 5;
   localparam int DRAIN_CYCLES = 20;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_BYTES = 105;

   localparam int FLAGS_HI_POS = 2;
   localparam int FLAGS_LO_POS = 3;
   localparam int QDCOUNT_HI_POS = 4;
   localparam int QDCOUNT_LO_POS = 5;
   localparam int ANCOUNT_HI_POS = 6;
   localparam int ANCOUNT_LO_POS = 7;
   localparam int NSCOUNT_HI_POS = 8;
   localparam int NSCOUNT_LO_POS = 9;
   localparam int ARCOUNT_HI_POS = 10;
   localparam int ARCOUNT_LO_POS = 11;

   localparam logic [7:0] FLAGS_HI_REPLY = 8'h81;
   localparam logic [7:0] FLAGS_LO_REPLY = 8'h80;
   localparam logic [7:0] ANCOUNT_LO_REPLY = 8'h01;
   localparam logic [7:0] POINTER_TAG = 8'hC0;
   localparam logic [7:0] RECORD_HEAD [12] = '{
      8'hC0, 8'h0C, 8'h00, 8'h01, 8'h00, 8'h01,
      8'h00, 8'h00, 8'h00, 8'h0A, 8'h00, 8'h04
   };

   typedef struct {
      logic [7:0] data_byte;
      logic       is_last;
      logic       frame_ok;
   } reply_type;

   class reply_tracker_type;
      logic [31:0] answer_address;
      bit [9:0]    byte_position;
      bit [9:0]    next_label_start;
      bit [9:0]    q_stop_pos;
      bit          name_done;
      bit          pointer_tail;
      bit          rejected;
      reply_type   pending[$];
      int          errors;
      int          replies_seen;

      function new();
         answer_address = '0;
         errors = 0;
         replies_seen = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         byte_position = '0;
         next_label_start = 10'(HEADER_BYTES);
         name_done = 1'b0;
         pointer_tail = 1'b0;
         q_stop_pos = '0;
         rejected = 1'b0;
      endfunction

      function void end_name(int pos);
         int qe;
         qe = pos + QUESTION_TRAILER;
         name_done = 1'b1;
         pointer_tail = 1'b0;
         if (qe + RECORD_BYTES > MAX_MESSAGE) begin
            rejected = 1'b1;
         end
         q_stop_pos = 10'(qe > POS_LIMIT ? POS_LIMIT : qe);
      endfunction

      function void note_query_byte(logic [7:0] b, logic eof);
         int        pos;
         int        jump;
         bit        keep;
         bit        ok;
         int        i;
         reply_type r;
         pos = int'(byte_position);
         if (pos < MAX_MESSAGE) begin
            r.data_byte = b;
            r.is_last = 1'b0;
            r.frame_ok = 1'b0;
            keep = 1'b1;
            if (pos < HEADER_BYTES) begin
               case (pos)
                  FLAGS_HI_POS: begin
                     if (b[7]) rejected = 1'b1;
                     r.data_byte = FLAGS_HI_REPLY;
                  end
                  FLAGS_LO_POS: r.data_byte = FLAGS_LO_REPLY;
                  QDCOUNT_HI_POS: if (b != 8'd0) rejected = 1'b1;
                  QDCOUNT_LO_POS: if (b != 8'd1) rejected = 1'b1;
                  ANCOUNT_LO_POS: r.data_byte = ANCOUNT_LO_REPLY;
                  ANCOUNT_HI_POS, NSCOUNT_HI_POS, NSCOUNT_LO_POS,
                  ARCOUNT_HI_POS, ARCOUNT_LO_POS: r.data_byte = 8'h00;
                  default: ;
               endcase
            end else if (!name_done) begin
               if (pointer_tail) begin
                  end_name(pos);
               end else if (pos == int'(next_label_start)) begin
                  if (b == 8'd0) begin
                     end_name(pos);
                  end else if ((b & POINTER_TAG) == POINTER_TAG) begin
                     pointer_tail = 1'b1;
                  end else begin
                     jump = pos + int'(b) + 1;
                     next_label_start = 10'(jump > POS_LIMIT ? POS_LIMIT : jump);
                  end
               end
            end else if (pos >= int'(q_stop_pos)) begin
               keep = 1'b0;
            end
            if (keep) pending.push_back(r);
            byte_position = 10'(pos + 1);
         end
         if (eof) begin
            ok = !rejected && int'(byte_position) >= HEADER_BYTES && name_done &&
                 q_stop_pos <= byte_position;
            for (i = 0; i < RECORD_BYTES; i++) begin
               r.data_byte = (i < 12) ? RECORD_HEAD[i] : answer_address[8*(15-i) +: 8];
               r.is_last = (i == RECORD_BYTES - 1);
               r.frame_ok = (i == RECORD_BYTES - 1) && ok;
               pending.push_back(r);
            end
            clear_frame();
         end
      endfunction

      function void check_reply_byte(logic [7:0] b, logic last, logic ok);
         reply_type want;
         replies_seen++;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) begin
               $display("reply %0d: unexpected transaction data %h last %b ok %b",
                        replies_seen, b, last, ok);
            end
         end else begin
            want = pending.pop_front();
            if (b !== want.data_byte || last !== want.is_last || ok !== want.frame_ok) begin
               errors++;
               if (errors <= 10) begin
                  $display("reply %0d: expected data %h last %b ok %b, got data %h last %b ok %b",
                           replies_seen, want.data_byte, want.is_last, want.frame_ok,
                           b, last, ok);
               end
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_end_of_frame;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_reply_byte;
   logic        rsp_reply_last;
   logic        rsp_frame_ok;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_answer_address;

   reply_tracker_type tracker = new();
   logic [7:0]        frame_bytes[$];
   int                sender_idle_pct;
   int                receiver_idle_pct;
   bit                long_hold_request;
   int                bytes_sent;
   int unsigned       cycle_count = 0;

   dns_query_fixed_answer_responder #(
      .MAX_MESSAGE(MAX_MESSAGE)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data_byte(req_data_byte),
      .req_end_of_frame(req_end_of_frame),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_reply_byte(rsp_reply_byte),
      .rsp_reply_last(rsp_reply_last),
      .rsp_frame_ok(rsp_frame_ok),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_answer_address(csr_answer_address)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         tracker.note_query_byte(req_data_byte, req_end_of_frame);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.check_reply_byte(rsp_reply_byte, rsp_reply_last, rsp_frame_ok);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // receiver with random stalls and one long hold-off
   initial begin : receiver
      int held;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            rsp_ready <= 1'b0;
            for (held = 0; held < LONG_HOLD_CYCLES; held++) @(negedge clock);
         end
         rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic eof);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_end_of_frame <= eof;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_frame();
      int i;
      for (i = 0; i < frame_bytes.size(); i++) begin
         send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
      end
      bytes_sent += frame_bytes.size();
      frame_bytes.delete();
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_address(input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_answer_address <= value;
      do @(posedge clock); while (!csr_ready);
      tracker.answer_address = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic put_random(input int count);
      repeat (count) frame_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic put_header(input bit qr_set, input bit bad_count);
      put_random(2);
      frame_bytes.push_back({qr_set, 7'($urandom_range(0, 127))});
      put_random(1);
      if (!bad_count) begin
         frame_bytes.push_back(8'h00);
         frame_bytes.push_back(8'h01);
      end else if ($urandom_range(0, 1)) begin
         frame_bytes.push_back(8'($urandom_range(1, 255)));
         put_random(1);
      end else begin
         frame_bytes.push_back(8'h00);
         frame_bytes.push_back($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(2, 255)));
      end
      repeat (6) begin
         frame_bytes.push_back($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255)) : 8'h00);
      end
   endtask

   task automatic put_question();
      int len;
      repeat ($urandom_range(0, 3)) begin
         len = ($urandom_range(0, 9) == 0) ? 63 : $urandom_range(1, 12);
         frame_bytes.push_back(8'(len));
         put_random(len);
      end
      if ($urandom_range(0, 3) == 0) begin
         frame_bytes.push_back(POINTER_TAG | 8'($urandom_range(0, 63)));
         put_random(1);
      end else begin
         frame_bytes.push_back(8'h00);
      end
      put_random(4);
      if ($urandom_range(0, 3) == 0) put_random($urandom_range(1, 8));
   endtask

   task automatic build_random_frame();
      int kind;
      int cut;
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
         put_header(1'b0, 1'b0);
         put_question();
      end else if (kind < 72) begin
         put_header(1'b1, 1'b0);
         put_question();
      end else if (kind < 79) begin
         put_header(1'b0, 1'b1);
         put_question();
      end else if (kind < 87) begin
         // truncated query
         put_header(1'b0, 1'b0);
         put_question();
         cut = $urandom_range(1, frame_bytes.size() - 1);
         while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
      end else if (kind < 93) begin
         // label length with 0x40 or 0x80 form
         put_header(1'b0, 1'b0);
         frame_bytes.push_back({$urandom_range(0, 1) ? 2'b01 : 2'b10, 6'($urandom_range(0, 63))});
         put_random($urandom_range(0, 20));
      end else begin
         put_random($urandom_range(1, 20));
      end
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct, input int budget);
      int start;
      sender_idle_pct = send_pct;
      receiver_idle_pct = recv_pct;
      start = bytes_sent;
      while (bytes_sent - start < budget) begin
         build_random_frame();
         send_frame();
      end
   endtask

   initial begin : stimulus
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = 8'h00;
      req_end_of_frame = 1'b0;
      csr_valid = 1'b0;
      csr_answer_address = 32'h0;
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      long_hold_request = 1'b0;
      bytes_sent = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      write_address(32'h0000_0000);
      // minimal root query, then a lone byte far under header size
      frame_bytes = '{8'hFF, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00,
                      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01};
      send_frame();
      frame_bytes.push_back(8'hFF);
      send_frame();

      wait_idle();
      write_address(32'hFFFF_FFFF);
      run_phase(21, 60, PHASE_BYTES);

      wait_idle();
      write_address($urandom);
      run_phase(60, 21, PHASE_BYTES);

      wait_idle();
      write_address($urandom);
      long_hold_request = 1'b1;
      run_phase(0, 0, PHASE_BYTES);

      wait_idle();
      if (tracker.errors == 0 && tracker.pending.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
